// ===== rtl/inverse_normal_quantile_assert.svh =====
// Assertion macros for the quantile pipeline
`ifndef INVERSE_NORMAL_QUANTILE_ASSERT_SVH
`define INVERSE_NORMAL_QUANTILE_ASSERT_SVH
`ifndef SYNTHESIS
`define INQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define INQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define INQ_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define INQ_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/inq_pkg.sv =====
// Package: constants and coefficients for the inverse normal quantile
`default_nettype none
package inq_pkg;
	localparam int unsigned QOUT_W = 21;
	localparam logic [40:0] TWO_LN2_Q26 = 41'd93032640;
	localparam logic signed [31:0] CP0 = -32'sd86498610;
	localparam logic signed [31:0] CP1 = -32'sd268435456;
	localparam logic signed [31:0] CP2 = -32'sd91869911;
	localparam logic signed [31:0] CP3 = -32'sd5482290;
	localparam logic signed [31:0] CP4 = -32'sd12177;
	localparam logic signed [31:0] CQ0 = 32'sd26668650;
	localparam logic signed [31:0] CQ1 = 32'sd157996162;
	localparam logic signed [31:0] CQ2 = 32'sd142567000;
	localparam logic signed [31:0] CQ3 = 32'sd27793204;
	localparam logic signed [31:0] CQ4 = 32'sd1035106;

	typedef enum logic [1:0] {
		K_NORMAL,
		K_LOW_ERR,
		K_HIGH_ERR,
		K_HALF
	} kind_t;

	// side information travelling with each item
	typedef struct packed {
		kind_t kind;
		logic  neg;
	} tag_t;
endpackage
`default_nettype wire

// ===== rtl/inverse_normal_quantile.sv =====
// Inverse standard normal CDF: deep pipeline, one probability per cycle unless out_stall freezes it
//
// Input channel: p_fraction with in_valid / in_stall. Output channel:
// quantile (signed, OUT_FRAC_BITS fraction bits) and range_error with
// out_valid / out_stall. A transaction completes on a clock edge with
// valid high and stall low.
// Throughput: one transaction per cycle unless a stall freezes the pipeline.
// Stages from the input edge to the output register: 30 log2 squaring
// stages, 28 square root bit steps, 8 Horner stages, 59 divider bit steps
// and 6 more stages (fold, normalise, y^2, divider prep, rounding, output).
// Every stage holds a valid bit. When out_stall is high and the output
// register is full the whole pipeline freezes and in_stall rises; no
// transaction is lost or repeated. Reset (arst_n low) clears all valid
// bits; payload registers are not reset.
// Probabilities below 1e-10 give the most negative code and range_error,
// above 1-1e-10 the most positive code and range_error, exactly one half
// gives zero.
`default_nettype none
`include "inverse_normal_quantile_assert.svh"
module inverse_normal_quantile
	import inq_pkg::*;
#(
	parameter int unsigned PROB_FRAC_BITS = 40,
	parameter int unsigned OUT_FRAC_BITS  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [39:0]              p_fraction,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [QOUT_W-1:0]      quantile,
	output logic                          range_error
);
	localparam int unsigned PB = PROB_FRAC_BITS;
	localparam logic [PB:0] FULL = {1'b1, {PB{1'b0}}};
	localparam logic [PB:0] HALF = {2'b01, {(PB-1){1'b0}}};
	localparam logic [PB:0] LIM = (FULL + (PB+1)'(64'd9999999999)) / (PB+1)'(64'd10000000000);
	localparam int unsigned NLOG = 30;
	localparam int unsigned NSQ = 28;   // sqrt of a 56-bit radicand bit pairs
	localparam int unsigned NPOL = 4;
	localparam int unsigned NDIV = 59;
	localparam int unsigned NS = 2 + NLOG + 1 + NSQ + NPOL*2 + 1 + NDIV + 2;
	localparam int unsigned RSH = 25 - OUT_FRAC_BITS;

	logic adv;
	logic [NS-1:0] v_q;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: classify, fold
	tag_t tag_s1;
	logic [PB-1:0] d_s1;
	logic [PB:0] x_c;
	assign x_c = {1'b0, PB'(p_fraction)};
	always_ff @(posedge clk) begin
		if (adv) begin
			if (x_c < LIM) tag_s1.kind <= K_LOW_ERR;
			else if (FULL - x_c < LIM) tag_s1.kind <= K_HIGH_ERR;
			else if (x_c == HALF) tag_s1.kind <= K_HALF;
			else tag_s1.kind <= K_NORMAL;
			tag_s1.neg <= x_c < HALF;
			d_s1 <= (x_c < HALF) ? x_c[PB-1:0] : PB'(FULL - x_c);
		end
	end

	// stage 2: normalise to Q1.30 (leading-one encode)
	tag_t tag_s2;
	logic [31:0] m_s2;
	logic [5:0] k_s2;
	logic [5:0] k_c;
	logic [63:0] dd;
	always_comb begin
		k_c = '0;
		for (int i = 0; i < PB; i++) if (d_s1[i]) k_c = 6'(i);
	end
	assign dd = 64'(d_s1);
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			k_s2 <= k_c;
			m_s2 <= (k_c >= 6'd30) ? 32'(dd >> (k_c - 6'd30)) : 32'(dd << (6'd30 - k_c));
		end
	end

	// log2 squaring chain, one bit per stage
	tag_t tag_l[NLOG+1];
	logic [31:0] m_l[NLOG+1];
	logic [29:0] f_l[NLOG+1];
	logic [5:0] k_l[NLOG+1];
	assign tag_l[0] = tag_s2;
	assign m_l[0] = m_s2;
	assign f_l[0] = '0;
	assign k_l[0] = k_s2;
	for (genvar g = 0; g < NLOG; g++) begin : g_log
		logic [63:0] sq;
		logic [33:0] sh;
		assign sq = 64'(m_l[g]) * 64'(m_l[g]);
		assign sh = sq[63:30];
		always_ff @(posedge clk) begin
			if (adv) begin
				tag_l[g+1] <= tag_l[g];
				k_l[g+1] <= k_l[g];
				if (sh[33:31] != 3'd0) begin
					m_l[g+1] <= sh[32:1];
					f_l[g+1] <= f_l[g] | (30'd1 << (29 - g));
				end else begin
					m_l[g+1] <= sh[31:0];
					f_l[g+1] <= f_l[g];
				end
			end
		end
	end

	// y^2 = L * 2ln2
	tag_t tag_y2;
	logic [55:0] rad_y2;
	logic [40:0] lval;
	logic [81:0] prod;
	assign lval = ({35'(PB) - 35'(k_l[NLOG]), 6'd0} << 24) - 41'(f_l[NLOG]);
	assign prod = 82'(lval) * 82'(TWO_LN2_Q26);
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_y2 <= tag_l[NLOG];
			rad_y2 <= 56'(prod >> 26) << 20;
		end
	end

	// restoring square root, one result bit per stage
	tag_t tag_r[NSQ+1];
	logic [51:0] rem_r[NSQ+1];
	logic [27:0] root_r[NSQ+1];
	logic [55:0] src_r[NSQ+1];
	assign tag_r[0] = tag_y2;
	assign rem_r[0] = '0;
	assign root_r[0] = '0;
	assign src_r[0] = rad_y2;
	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		logic [53:0] trial, remn;
		assign remn = {rem_r[g], src_r[g][55:54]};
		assign trial = remn - {24'd0, root_r[g], 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				tag_r[g+1] <= tag_r[g];
				src_r[g+1] <= src_r[g] << 2;
				if (!trial[53]) begin
					rem_r[g+1] <= trial[51:0];
					root_r[g+1] <= {root_r[g][26:0], 1'b1};
				end else begin
					rem_r[g+1] <= remn[51:0];
					root_r[g+1] <= {root_r[g][26:0], 1'b0};
				end
			end
		end
	end

	// Horner, two stages per step: multiply, then shift and add
	localparam logic signed [31:0] PC[5] = '{CP4, CP3, CP2, CP1, CP0};
	localparam logic signed [31:0] QC[5] = '{CQ4, CQ3, CQ2, CQ1, CQ0};
	tag_t tag_h[NPOL+1];
	logic signed [39:0] pa_h[NPOL+1], qa_h[NPOL+1];
	logic signed [28:0] y_h[NPOL+1];
	assign tag_h[0] = tag_r[NSQ];
	assign y_h[0] = $signed({1'b0, root_r[NSQ]});
	assign pa_h[0] = 40'(PC[0]);
	assign qa_h[0] = 40'(QC[0]);
	for (genvar g = 0; g < NPOL; g++) begin : g_horn
		tag_t tg_m;
		logic signed [28:0] y_m;
		logic signed [66:0] pm_m, qm_m;
		always_ff @(posedge clk) begin
			if (adv) begin
				tg_m <= tag_h[g];
				y_m <= y_h[g];
				pm_m <= 67'(pa_h[g]) * 67'(y_h[g]);
				qm_m <= 67'(qa_h[g]) * 67'(y_h[g]);
				tag_h[g+1] <= tg_m;
				y_h[g+1] <= y_m;
				pa_h[g+1] <= 40'(pm_m >>> 25) + 40'(PC[g+1]);
				qa_h[g+1] <= 40'(qm_m >>> 25) + 40'(QC[g+1]);
			end
		end
	end

	// sign-magnitude prep for the divider
	tag_t tag_d0;
	logic pneg_d0, qok_d0;
	logic [58:0] num_d0;
	logic [39:0] den_d0;
	logic [27:0] y_d0;
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_d0 <= tag_h[NPOL];
			y_d0 <= y_h[NPOL][27:0];
			pneg_d0 <= pa_h[NPOL] < 0;
			qok_d0 <= qa_h[NPOL] > 0;
			num_d0 <= 59'(pa_h[NPOL] < 0 ? -pa_h[NPOL] : pa_h[NPOL]) << 25;
			den_d0 <= qa_h[NPOL];
		end
	end

	// restoring divider, one quotient bit per stage
	tag_t tag_v[NDIV+1];
	logic pn_v[NDIV+1], qk_v[NDIV+1];
	logic [27:0] y_v[NDIV+1];
	logic [39:0] dn_v[NDIV+1];
	logic [58:0] nq_v[NDIV+1];
	logic [40:0] rm_v[NDIV+1];
	assign tag_v[0] = tag_d0;
	assign pn_v[0] = pneg_d0;
	assign qk_v[0] = qok_d0;
	assign y_v[0] = y_d0;
	assign dn_v[0] = den_d0;
	assign nq_v[0] = num_d0;
	assign rm_v[0] = '0;
	for (genvar g = 0; g < NDIV; g++) begin : g_div
		logic [41:0] sh, tr;
		assign sh = {rm_v[g], nq_v[g][58]};
		assign tr = sh - {2'b00, dn_v[g]};
		always_ff @(posedge clk) begin
			if (adv) begin
				tag_v[g+1] <= tag_v[g];
				pn_v[g+1] <= pn_v[g];
				qk_v[g+1] <= qk_v[g];
				y_v[g+1] <= y_v[g];
				dn_v[g+1] <= dn_v[g];
				if (!tr[41]) begin
					rm_v[g+1] <= tr[40:0];
					nq_v[g+1] <= {nq_v[g][57:0], 1'b1};
				end else begin
					rm_v[g+1] <= sh[40:0];
					nq_v[g+1] <= {nq_v[g][57:0], 1'b0};
				end
			end
		end
	end

	// magnitude and rounding
	tag_t tag_m;
	logic signed [57:0] mag_m;
	logic signed [57:0] ratio_c;
	assign ratio_c = !qk_v[NDIV] ? 58'sd0 :
		(pn_v[NDIV] ? -$signed({1'b0, nq_v[NDIV][56:0]}) : $signed({1'b0, nq_v[NDIV][56:0]}));
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_m <= tag_v[NDIV];
			mag_m <= ($signed(58'(y_v[NDIV])) + ratio_c +
				(58'sd1 <<< (24 - OUT_FRAC_BITS))) >>> RSH;
		end
	end

	// output register with saturation
	localparam logic signed [57:0] QMAX = (58'sd1 <<< (QOUT_W-1)) - 58'sd1;
	localparam logic signed [57:0] QMIN = -(58'sd1 <<< (QOUT_W-1));
	logic signed [57:0] sv_c;
	assign sv_c = tag_m.neg ? -mag_m : mag_m;
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (tag_m.kind)
				K_LOW_ERR: begin
					quantile <= QOUT_W'(QMIN);
					range_error <= 1'b1;
				end
				K_HIGH_ERR: begin
					quantile <= QOUT_W'(QMAX);
					range_error <= 1'b1;
				end
				K_HALF: begin
					quantile <= '0;
					range_error <= 1'b0;
				end
				default: begin
					quantile <= (sv_c > QMAX) ? QOUT_W'(QMAX) :
						(sv_c < QMIN) ? QOUT_W'(QMIN) : QOUT_W'(sv_c);
					range_error <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], in_valid};
		end
	end
	assign out_valid = v_q[NS-1];

	`INQ_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(quantile), "stalled result changed")
	`INQ_ASSERT_IMP(a_stall, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output stall")
	`INQ_ASSERT_IMP(a_err, clk, arst_n, out_valid && range_error, quantile == QOUT_W'(QMIN) || quantile == QOUT_W'(QMAX), "range error without saturated code")
endmodule
`default_nettype wire

// ===== dv/quantile_checker.sv =====
// Checker for the inverse normal quantile block: watches both channels, predicts, compares
`timescale 1ns / 1ps
module quantile_checker
	import inq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic [39:0]              p_fraction,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic signed [QOUT_W-1:0] quantile,
	input  wire logic                     range_error,
	output int                            fail_count,
	output int                            pending
);
	localparam int unsigned PBITS = 40;
	localparam int unsigned OBITS = 16;
	localparam longint unsigned LIM = ((64'd1 << PBITS) + 64'd9999999999) / 64'd10000000000;

	typedef struct packed {
		logic signed [QOUT_W-1:0] q;
		logic                     err;
	} quantile_t;

	quantile_t quantile_queue[$];

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint poly_eval(longint y, longint c4, longint c3, longint c2,
			longint c1, longint c0);
		longint acc;
		acc = c4;
		acc = floor_sh(acc * y, 25) + c3;
		acc = floor_sh(acc * y, 25) + c2;
		acc = floor_sh(acc * y, 25) + c1;
		acc = floor_sh(acc * y, 25) + c0;
		return acc;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic quantile_t predict_quantile(logic [39:0] p);
		longint unsigned x, full, half, d, m, frac, lval, y2, y;
		longint pv, qv, ratio, mag, res;
		int k;
		logic neg;
		quantile_t r;
		x = 64'(p);
		full = 64'd1 << PBITS;
		half = 64'd1 << (PBITS - 1);
		r.err = 1'b0;
		if (x < LIM) begin
			r.q = QOUT_W'(-(1 <<< (QOUT_W - 1)));
			r.err = 1'b1;
			return r;
		end
		if (full - x < LIM) begin
			r.q = QOUT_W'((1 << (QOUT_W - 1)) - 1);
			r.err = 1'b1;
			return r;
		end
		if (x == half) begin
			r.q = '0;
			return r;
		end
		neg = x < half;
		d = neg ? x : full - x;
		k = 0;
		while (k < 63 && (d >> (k + 1)) != 0) k++;
		m = (k >= 30) ? d >> (k - 30) : d << (30 - k);
		frac = 0;
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 64'd1 << (29 - i);
			end
		end
		lval = (longint'(PBITS - k) << 30) - frac;
		y2 = (lval * 64'd93032640) >> 26;
		y = isqrt(y2 << 20);
		pv = poly_eval(y, CP4, CP3, CP2, CP1, CP0);
		qv = poly_eval(y, CQ4, CQ3, CQ2, CQ1, CQ0);
		ratio = (qv > 0) ? (pv * (64'sd1 <<< 25)) / qv : 0;
		mag = floor_sh(longint'(y) + ratio + (64'sd1 <<< (24 - OBITS)), 25 - OBITS);
		res = neg ? -mag : mag;
		if (res > (1 <<< (QOUT_W - 1)) - 1) res = (1 <<< (QOUT_W - 1)) - 1;
		if (res < -(1 <<< (QOUT_W - 1))) res = -(1 <<< (QOUT_W - 1));
		r.q = res[QOUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quantile_t want;
		if (!arst_n) begin
			quantile_queue.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				quantile_queue.push_back(predict_quantile(p_fraction));
			if (out_valid && !out_stall) begin
				if (quantile_queue.size() == 0) begin
					$display("%0t: unexpected transaction q=%0d err=%0b", $time,
						quantile, range_error);
					fail_count++;
				end else begin
					want = quantile_queue.pop_front();
					if (quantile !== want.q) begin
						$display("%0t: quantile expected %0d actual %0d", $time,
							want.q, quantile);
						fail_count++;
					end
					if (range_error !== want.err) begin
						$display("%0t: range_error expected %0b actual %0b", $time,
							want.err, range_error);
						fail_count++;
					end
				end
			end
		end
		pending = quantile_queue.size();
	end
endmodule

// ===== dv/tb_inverse_normal_quantile.sv =====
// Testbench top for the inverse normal quantile block: stimulus and verdict
`timescale 1ns / 1ps
module tb_inverse_normal_quantile
	import inq_pkg::*;
();

	localparam longint unsigned FULL = 64'd1 << 40;
	localparam longint unsigned LIM = 64'd110;
	localparam int unsigned LATENCY = 131;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [39:0] p_fraction = '0;
	logic out_stall = 1'b0;
	wire in_stall, out_valid, range_error;
	wire signed [QOUT_W-1:0] quantile;
	int fail_count, pending;
	int gap_pct = 0, stall_pct = 0;
	longint unsigned cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	inverse_normal_quantile dut (.*);

	quantile_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_inverse_normal_quantile: errors");
			$finish;
		end
	end

	// leaves valid low for a random gap, then holds p until the transaction is taken
	task automatic send_prob(logic [39:0] p);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		p_fraction <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [39:0] random_prob();
		longint unsigned r;
		case ($urandom_range(5))
			0: r = $urandom_range(300);
			1: r = FULL - 1 - $urandom_range(300);
			2: r = {$urandom, $urandom} & (FULL - 1);
			// logarithmic spread across the tails
			3: r = ({$urandom, $urandom} & (FULL - 1)) >> $urandom_range(39);
			4: r = FULL - 1 - (({$urandom, $urandom} & (FULL - 1)) >> $urandom_range(39));
			default: r = (FULL >> 1) + $urandom_range(2000) - 1000;
		endcase
		return r[39:0];
	endfunction

	initial begin
		logic [39:0] directed[$];
		directed = '{40'd0, 40'd1, LIM - 1, LIM, LIM + 1, FULL - LIM, FULL - LIM + 1,
			FULL - LIM - 1, FULL - 1, FULL >> 1, (FULL >> 1) - 1, (FULL >> 1) + 1,
			FULL >> 2, FULL - (FULL >> 2), 40'h5555555555, 40'hAAAAAAAAAA,
			40'h0123456789, 40'hFEDCBA9876, 40'd1000000, FULL - 1000000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_prob(directed[i]);
		// phases: no idling, sender idle, receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			gap_pct = (phase == 1) ? 52 : (phase == 3 ? 6 : 0);
			stall_pct = (phase == 2) ? 52 : (phase == 3 ? 6 : 0);
			repeat (400) send_prob(random_prob());
		end
		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_inverse_normal_quantile: clean");
		else
			$display("tb_inverse_normal_quantile: errors");
		$finish;
	end
endmodule
